### rtl/rc5ird_pkg.sv
// Shared types and constants of the RC5 infrared edge decoder.
package rc5ird_pkg;

   localparam int CFG_W        = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int HALF_W       = 6;
   localparam int SHIFT_W      = 13;
   localparam int BIT_CNT_W    = 4;
   localparam int ADDR_W       = 5;
   localparam int CMD_W        = 6;
   localparam int FIELDS_W     = 12;
   localparam int TOGGLE_POS   = 11;
   localparam int ADDR_LSB     = 6;
   localparam int RSP_TDATA_W  = 16;

   localparam logic [BIT_CNT_W-1:0] FRAME_BITS = 4'd13;

   localparam logic [CSR_INDEX_W-1:0] REG_MIN_HALF_BIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_HALF_BIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BIT      = 2'd2;

   localparam logic [CFG_W-1:0] MIN_HALF_BIT_RESET = 16'd640;
   localparam logic [CFG_W-1:0] MAX_HALF_BIT_RESET = 16'd1140;
   localparam logic [CFG_W-1:0] MAX_BIT_RESET      = 16'd2000;

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] max_bit;
      logic [CFG_W-1:0] max_half_bit;
      logic [CFG_W-1:0] min_half_bit;
   } cfg_type;

   // Packed so that frame_ready lands in the lowest bit.
   typedef struct packed {
      logic              capture_rising_next;
      logic              toggle;
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] address;
      logic              frame_ready;
   } result_type;

endpackage

### rtl/rc5_ir_edge_decoder.sv
// Top level of the RC5 infrared edge decoder: input register, decode step, result register.
//
// The decoder takes one word per edge of the infrared receiver (or a clear
// command) and returns exactly one result word for each. An edge word carries
// the timer value captured at that edge; the block measures the interval since
// the previous edge, tracks the half-bit phase of the Manchester code and, once
// 13 bits are in, latches the toggle bit, the five-bit address and the six-bit
// command and raises frame_ready. A new frame is not latched while frame_ready
// is still set; a clear word (tuser high) drops the flag. Every result word
// reports the flag, the latched frame fields and the edge polarity to arm the
// capture unit for next. Throughput is one word per clock while the result side
// takes each result as it appears: the decode step is a single pass of compare
// and increment logic between the input register and the result register, and
// the decoder state closes its loop within that cycle. An accepted word waits in
// the input register and passes through the decode step into the result register
// once that register is empty or its content is being taken; while a result waits,
// the word waits in the input register. The input accepts a new word while a
// finished result waits to be taken; it stalls only when both the input register
// and the result register are full. Thresholds are 16-bit registers written through
// the csr port; the user must write them only while idle, which the block does not enforce.
module rc5_ir_edge_decoder #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input words.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((TIME_WIDTH+7)/8)*8-1:0]       req_tdata,  // capture_time, then zero fill
   input  logic                                  req_tuser,  // op: 0 edge, 1 clear ready flag
   // Result words.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rc5ird_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // frame_ready, address[4:0],
                                                             // command[5:0], toggle,
                                                             // capture_rising_next, 2'b0
   // Threshold registers.
   input  logic                                  csr_we,
   input  logic [rc5ird_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rc5ird_pkg::CFG_W-1:0]          csr_wdata
);

   rc5ird_pkg::cfg_type    cfg;
   rc5ird_pkg::result_type result;

   logic                   in_valid_ff, in_valid_in;
   logic                   in_op_ff;
   logic [TIME_WIDTH-1:0]  in_time_ff;
   logic                   out_valid_ff, out_valid_in;
   rc5ird_pkg::result_type out_result_ff;
   logic                   advance;
   logic                   take_in;

   // The held word moves into the result register when that register is
   // empty or its content is being taken this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take_in    = req_tvalid && req_tready;

   assign in_valid_in  = take_in || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_op_ff   <= req_tuser;
         in_time_ff <= req_tdata[TIME_WIDTH-1:0];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   rc5ird_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rc5ird_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .op           (in_op_ff),
      .capture_time (in_time_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rc5ird_pkg::RSP_TDATA_W'(out_result_ff);

   // The input side never stalls unless a result is being held back.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && !rsp_tready) |-> req_tready)
      else $error("input stalled although the result side is free");

   // A word that enters the decode step shows up as a result next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("decoded word did not reach the result register");

   // A clear word always reports the ready flag as dropped.
   a_clear_drops_flag: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == rc5ird_pkg::OP_CLEAR) |=> !out_result_ff.frame_ready)
      else $error("clear word did not drop frame_ready");

   // An edge word never drops a ready flag that is already set.
   a_flag_sticks: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == rc5ird_pkg::OP_EDGE && rsp_tvalid
       && out_result_ff.frame_ready) |=> out_result_ff.frame_ready)
      else $error("edge word cleared frame_ready");

endmodule

### rtl/rc5ird_csr.sv
// Timing threshold registers of the RC5 decoder.
module rc5ird_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rc5ird_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rc5ird_pkg::CFG_W-1:0]        csr_wdata,
   output rc5ird_pkg::cfg_type                 cfg
);

   rc5ird_pkg::cfg_type cfg_ff;
   rc5ird_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rc5ird_pkg::REG_MIN_HALF_BIT: cfg_in.min_half_bit = csr_wdata;
            rc5ird_pkg::REG_MAX_HALF_BIT: cfg_in.max_half_bit = csr_wdata;
            rc5ird_pkg::REG_MAX_BIT:      cfg_in.max_bit      = csr_wdata;
            default:                      cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_half_bit <= rc5ird_pkg::MIN_HALF_BIT_RESET;
         cfg_ff.max_half_bit <= rc5ird_pkg::MAX_HALF_BIT_RESET;
         cfg_ff.max_bit      <= rc5ird_pkg::MAX_BIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/rc5ird_core.sv
// Frame decoding state and the per-word update step of the RC5 decoder.
module rc5ird_core #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   op,
   input  logic [TIME_WIDTH-1:0]  capture_time,
   input  rc5ird_pkg::cfg_type    cfg,
   output rc5ird_pkg::result_type result
);

   localparam int CMP_W = (TIME_WIDTH > rc5ird_pkg::CFG_W) ? TIME_WIDTH : rc5ird_pkg::CFG_W;

   logic [TIME_WIDTH-1:0]                last_ff,  last_in;
   logic                                 edge_ff,  edge_in;
   logic [rc5ird_pkg::HALF_W-1:0]        half_ff,  half_in;
   logic [rc5ird_pkg::SHIFT_W-1:0]       shift_ff, shift_in;
   logic [rc5ird_pkg::BIT_CNT_W-1:0]     bits_ff,  bits_in;
   logic                                 ready_ff, ready_in;
   logic [rc5ird_pkg::FIELDS_W-1:0]      fields_ff, fields_in;

   logic [TIME_WIDTH-1:0]                interval;
   logic [CMP_W-1:0]                     interval_x;
   logic [rc5ird_pkg::HALF_W-1:0]        half_start;
   logic [rc5ird_pkg::HALF_W-1:0]        half_adv;
   logic [rc5ird_pkg::SHIFT_W-1:0]       shift_next;
   logic [rc5ird_pkg::BIT_CNT_W-1:0]     bits_next;

   always_comb begin
      interval   = capture_time - last_ff;
      interval_x = CMP_W'(interval);
      half_start = (interval_x > CMP_W'(cfg.max_bit)) ? '0 : half_ff;
      half_adv   = (interval_x > CMP_W'(cfg.max_half_bit)) ? half_start + 1'b1 : half_start;
      shift_next = {shift_ff[rc5ird_pkg::SHIFT_W-2:0], ~edge_ff};
      bits_next  = bits_ff + 1'b1;

      last_in   = last_ff;
      edge_in   = edge_ff;
      half_in   = half_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      ready_in  = ready_ff;
      fields_in = fields_ff;

      if (op == rc5ird_pkg::OP_CLEAR) begin
         ready_in = 1'b0;
      end else begin
         last_in = capture_time;
         edge_in = ~edge_ff;
         if (half_start == '0) begin
            // First edge of a frame only synchronizes the bit clock.
            shift_in = '0;
            bits_in  = '0;
            edge_in  = 1'b1;
            half_in  = rc5ird_pkg::HALF_W'(1);
         end else if (interval_x < CMP_W'(cfg.min_half_bit)) begin
            half_in = '0;
            edge_in = 1'b0;
         end else if (half_adv > rc5ird_pkg::HALF_W'(1) && !half_adv[0]) begin
            // Mid-bit edge: its polarity is the data bit.
            shift_in = shift_next;
            bits_in  = bits_next;
            if (bits_next >= rc5ird_pkg::FRAME_BITS) begin
               if (!ready_ff) begin
                  fields_in = shift_next[rc5ird_pkg::FIELDS_W-1:0];
               end
               ready_in = 1'b1;
               half_in  = '0;
               edge_in  = 1'b0;
            end else begin
               half_in = half_adv + 1'b1;
            end
         end else begin
            half_in = half_adv + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         edge_ff   <= 1'b0;
         half_ff   <= '0;
         shift_ff  <= '0;
         bits_ff   <= '0;
         ready_ff  <= 1'b0;
         fields_ff <= '0;
      end else if (step) begin
         last_ff   <= last_in;
         edge_ff   <= edge_in;
         half_ff   <= half_in;
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
         ready_ff  <= ready_in;
         fields_ff <= fields_in;
      end
   end

   always_comb begin
      result.frame_ready         = ready_in;
      result.address             = fields_in[rc5ird_pkg::ADDR_LSB +: rc5ird_pkg::ADDR_W];
      result.command             = fields_in[rc5ird_pkg::CMD_W-1:0];
      result.toggle              = fields_in[rc5ird_pkg::TOGGLE_POS];
      result.capture_rising_next = edge_in;
   end

endmodule
